FILE: rtl/subband_qmf_analysis_24tap_defines.svh
// Assertion macros shared by the filter bank RTL.
`ifndef SUBBAND_QMF_ANALYSIS_24TAP_DEFINES_SVH
`define SUBBAND_QMF_ANALYSIS_24TAP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SQMF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SQMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sqmf_pkg.sv
package sqmf_pkg;

  localparam int NUM_TAPS  = 24;
  localparam int TAP_W     = $clog2(NUM_TAPS);
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 14;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int SUM_W     = 32;
  localparam int BAND_W    = 15;

  // Control from the sequencer to the sample ring.
  typedef struct packed {
    logic wr_en;
    logic rd_step;
  } ring_ctrl_t;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clr;
    logic issue;
    logic odd;
  } mac_ctrl_t;

  // Next ring slot, wrapping at the end of the ring.
  function automatic logic [TAP_W-1:0] next_slot(input logic [TAP_W-1:0] p);
    logic [TAP_W-1:0] r;
    if (p == TAP_W'(NUM_TAPS - 1)) begin
      r = '0;
    end else begin
      r = p + TAP_W'(1);
    end
    return r;
  endfunction

  // Symmetric QMF coefficient for a tap, oldest sample first.
  function automatic logic signed [COEF_W-1:0] qmf_coef(input logic [TAP_W-1:0] t);
    logic signed [COEF_W-1:0] c;
    case (t)
      5'd0,  5'd23: c = 14'sd1;
      5'd1,  5'd22: c = -14'sd11;
      5'd2,  5'd21: c = -14'sd11;
      5'd3,  5'd20: c = 14'sd53;
      5'd4,  5'd19: c = 14'sd12;
      5'd5,  5'd18: c = -14'sd156;
      5'd6,  5'd17: c = 14'sd32;
      5'd7,  5'd16: c = 14'sd362;
      5'd8,  5'd15: c = -14'sd210;
      5'd9,  5'd14: c = -14'sd805;
      5'd10, 5'd13: c = 14'sd951;
      5'd11, 5'd12: c = 14'sd3876;
      default:      c = '0;
    endcase
    return c;
  endfunction

  // Divide by 8192 truncating toward zero, then saturate to the band range.
  function automatic logic signed [BAND_W-1:0] div_sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] b;
    logic signed [SUM_W-14:0] q;
    logic signed [BAND_W-1:0] r;
    b = v + (v[SUM_W-1] ? SUM_W'(8191) : SUM_W'(0));
    q = b[SUM_W-1:13];
    if (q > (SUM_W-13)'(16383)) begin
      r = 15'sh3FFF;
    end else if (q < -(SUM_W-13)'(16384)) begin
      r = 15'sh4000;
    end else begin
      r = q[BAND_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/subband_qmf_analysis_24tap.sv
// The 24 taps share one multiply-accumulate unit.
// The block takes no item until the current result has been loaded for output.
// Reset (rst, synchronous): sample ring cleared to zero, write slot zero,
// sequencer idle, no result pending.
module subband_qmf_analysis_24tap (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [sqmf_pkg::SAMPLE_W-1:0]  first_sample,
  input  logic signed [sqmf_pkg::SAMPLE_W-1:0]  second_sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [sqmf_pkg::BAND_W-1:0]    low_band,
  output logic signed [sqmf_pkg::BAND_W-1:0]    high_band
);
  import sqmf_pkg::*;
  `include "subband_qmf_analysis_24tap_defines.svh"

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_WR2   = 5'b00010,
    ST_MAC   = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  state_t                     state;
  state_t                     state_next;
  logic [TAP_W-1:0]           tap_cnt;
  logic signed [SAMPLE_W-1:0] second_hold;
  logic                       accept;
  logic                       load_out;
  ring_ctrl_t                 ring_ctrl;
  mac_ctrl_t                  mac_ctrl;
  logic signed [SAMPLE_W-1:0] ring_wdata;
  logic signed [SAMPLE_W-1:0] ring_rdata;
  logic signed [SUM_W-1:0]    sum_a;
  logic signed [SUM_W-1:0]    sum_b;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign load_out = (state == ST_FIN) && (!out_valid || !out_stall);

  // Sequencer transitions.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_WR2;
      ST_WR2:   state_next = ST_MAC;
      ST_MAC:   if (tap_cnt == TAP_W'(NUM_TAPS - 1)) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_FIN;
      ST_FIN:   if (load_out) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      tap_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_MAC) begin
        tap_cnt <= next_slot(tap_cnt);
      end else begin
        tap_cnt <= '0;
      end
    end
  end

  // The later sample is held and written in the cycle after, through the ring's single write port.
  always_ff @(posedge clk) begin
    if (accept) begin
      second_hold <= second_sample;
    end
  end

  always_comb begin
    ring_ctrl.wr_en   = accept || (state == ST_WR2);
    ring_ctrl.rd_step = (state == ST_MAC);
    ring_wdata        = (state == ST_WR2) ? second_hold : first_sample;
    mac_ctrl.clr      = accept;
    mac_ctrl.issue    = (state == ST_MAC);
    mac_ctrl.odd      = tap_cnt[0];
  end

  sqmf_ring u_ring (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ring_ctrl),
    .wdata (ring_wdata),
    .rdata (ring_rdata)
  );

  sqmf_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .sample (ring_rdata),
    .coef   (qmf_coef(tap_cnt)),
    .sum_a  (sum_a),
    .sum_b  (sum_b)
  );

  // Output register: scale, saturate and hold until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      low_band  <= div_sat(sum_a + sum_b);
      high_band <= div_sat(sum_a - sum_b);
    end
  end

  `SQMF_ASSERT_NEXT(a_accept_starts_seq, accept, state == ST_WR2, "accept did not start sequence")
  `SQMF_ASSERT_NOW(a_tap_in_range, 1'b1, tap_cnt < TAP_W'(NUM_TAPS), "tap counter out of range")
  `SQMF_ASSERT_NOW(a_result_from_fin, $rose(out_valid), $past(state == ST_FIN), "result not from finish")

endmodule

FILE: rtl/sqmf_ring.sv
module sqmf_ring (
  input  logic                                  clk,
  input  logic                                  rst,
  input  sqmf_pkg::ring_ctrl_t                  ctrl,
  input  logic signed [sqmf_pkg::SAMPLE_W-1:0]  wdata,
  output logic signed [sqmf_pkg::SAMPLE_W-1:0]  rdata
);
  import sqmf_pkg::*;

  logic signed [SAMPLE_W-1:0] ring [NUM_TAPS];
  logic [TAP_W-1:0]           wr_idx;
  logic [TAP_W-1:0]           rd_idx;

  // Past samples; the write slot is always the oldest entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TAPS; i++) begin
        ring[i] <= '0;
      end
    end else if (ctrl.wr_en) begin
      ring[wr_idx] <= wdata;
    end
  end

  // After a write the read pointer sits on the oldest sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
    end else if (ctrl.wr_en) begin
      wr_idx <= next_slot(wr_idx);
      rd_idx <= next_slot(wr_idx);
    end else if (ctrl.rd_step) begin
      rd_idx <= next_slot(rd_idx);
    end
  end

  assign rdata = ring[rd_idx];

endmodule

FILE: rtl/sqmf_mac.sv
module sqmf_mac (
  input  logic                                  clk,
  input  logic                                  rst,
  input  sqmf_pkg::mac_ctrl_t                   ctrl,
  input  logic signed [sqmf_pkg::SAMPLE_W-1:0]  sample,
  input  logic signed [sqmf_pkg::COEF_W-1:0]    coef,
  output logic signed [sqmf_pkg::SUM_W-1:0]     sum_a,
  output logic signed [sqmf_pkg::SUM_W-1:0]     sum_b
);
  import sqmf_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic                     prod_vld;
  logic                     prod_odd;

  // Multiply stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctrl.issue;
    end
    prod     <= sample * coef;
    prod_odd <= ctrl.odd;
  end

  // Accumulate stage: odd taps into sum A, even taps into sum B.
  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      sum_a <= '0;
      sum_b <= '0;
    end else if (prod_vld) begin
      if (prod_odd) begin
        sum_a <= sum_a + SUM_W'(prod);
      end else begin
        sum_b <= sum_b + SUM_W'(prod);
      end
    end
  end

endmodule
